/* hw/rtl/smf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types, sizes and helpers for the strict-priority message FIFO bank.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int CHANNELS = 8;
  localparam int DEPTH    = 512;

  localparam int CH_IN_W  = 4;                     // channel_in field
  localparam int CH_OUT_W = 3;                     // channel_out field
  localparam int CFG_W    = 3;                     // config register width
  localparam int CFG_IDX_W = 1;
  localparam int WORD_W   = 32;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MEM_AW = CH_W + IDX_W;

  typedef enum logic [1:0] {
    OP_POST  = 2'd0,
    OP_GET   = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHANNEL   = 1'd1;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic [WORD_W-1:0] word_w;
    logic [WORD_W-1:0] word_l;
    logic [WORD_W-1:0] word_z;
  } msg_t;

  // circular index advance, wraps at DEPTH-1
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/smf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_in_if / smf_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface smf_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  op;
  logic [smf_pkg::CH_IN_W-1:0] channel_in;
  logic [smf_pkg::WORD_W-1:0]  code_in;
  logic [smf_pkg::WORD_W-1:0]  word_w_in;
  logic [smf_pkg::WORD_W-1:0]  word_l_in;
  logic [smf_pkg::WORD_W-1:0]  word_z_in;

  modport source (output valid, op, channel_in, code_in, word_w_in, word_l_in, word_z_in,
                  input ready);
  modport sink   (input valid, op, channel_in, code_in, word_w_in, word_l_in, word_z_in,
                  output ready);
endinterface

interface smf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [smf_pkg::CH_OUT_W-1:0] channel_out;
  logic [smf_pkg::WORD_W-1:0]   code_out;
  logic [smf_pkg::WORD_W-1:0]   word_w_out;
  logic [smf_pkg::WORD_W-1:0]   word_l_out;
  logic [smf_pkg::WORD_W-1:0]   word_z_out;

  modport source (output valid, ok, channel_out, code_out, word_w_out, word_l_out,
                  word_z_out, input ready);
  modport sink   (input valid, ok, channel_out, code_out, word_w_out, word_l_out,
                  word_z_out, output ready);
endinterface

/* hw/rtl/strict_priority_multi_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Bank of per-channel circular message FIFOs with a lowest-channel-first pop.
// ----------------------------------------------------------------------------
// One request beat is taken every cycle unless a held result beat is not yet
// taken. Acceptance loads the input register, and its advance loads the result
// register, which also holds the message store read data. Post, get and flush
// each finish in a single pass: an eight-way priority encode over the
// per-channel non-empty flags plus at most one access to the single-port message
// store. Head, tail and fill counters live in flops and reset to empty; the
// store itself is never cleared, so the block is ready right after reset.
module strict_priority_multi_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  smf_in_if.sink                        in_chan,
  smf_out_if.source                     out_chan,
  input  logic                          cfg_wr_en,
  input  logic [smf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smf_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CH_W   = smf_pkg::CH_W;
  localparam int IDX_W  = smf_pkg::IDX_W;
  localparam int CNT_W  = smf_pkg::CNT_W;
  localparam int MEM_AW = smf_pkg::MEM_AW;

  // configuration
  logic [smf_pkg::CFG_W-1:0] touch_ch_r;
  logic [smf_pkg::CFG_W-1:0] key_ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_ch_r <= smf_pkg::CFG_W'(0);
      key_ch_r   <= smf_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        smf_pkg::CFG_TOUCH_CHANNEL: touch_ch_r <= cfg_wdata;
        smf_pkg::CFG_KEY_CHANNEL:   key_ch_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic                          s1_valid_r;
  smf_pkg::op_t                  s1_op_r;
  logic [smf_pkg::CH_IN_W-1:0]   s1_ch_r;
  smf_pkg::msg_t                 s1_msg_r;
  logic                          s1_adv;
  logic                          s1_fire;
  logic                          in_fire;
  logic                          out_valid_r;

  assign s1_adv         = !out_valid_r || out_chan.ready;
  assign s1_fire        = s1_valid_r && s1_adv;
  assign in_chan.ready  = !s1_valid_r || s1_adv;
  assign in_fire        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r         <= smf_pkg::op_t'(in_chan.op);
      s1_ch_r         <= in_chan.channel_in;
      s1_msg_r.code   <= in_chan.code_in;
      s1_msg_r.word_w <= in_chan.word_w_in;
      s1_msg_r.word_l <= in_chan.word_l_in;
      s1_msg_r.word_z <= in_chan.word_z_in;
    end
  end

  // per-channel queue state
  logic [IDX_W-1:0] head_r   [smf_pkg::CHANNELS];
  logic [IDX_W-1:0] tail_r   [smf_pkg::CHANNELS];
  logic [CNT_W-1:0] fill_r   [smf_pkg::CHANNELS];
  logic [IDX_W-1:0] head_nxt [smf_pkg::CHANNELS];
  logic [IDX_W-1:0] tail_nxt [smf_pkg::CHANNELS];
  logic [CNT_W-1:0] fill_nxt [smf_pkg::CHANNELS];

  logic [smf_pkg::CHANNELS-1:0] nonempty;
  logic [CH_W-1:0]              sel;
  logic                         any_msg;
  logic [CH_W-1:0]              post_ch;
  logic                         post_in_range;
  logic                         post_ok;
  logic                         get_ok;
  logic                         res_ok;
  logic                         over_fill;

  // lowest-numbered non-empty channel wins
  always_comb begin
    sel     = '0;
    any_msg = 1'b0;
    for (int c = smf_pkg::CHANNELS - 1; c >= 0; c--) begin
      nonempty[c] = (fill_r[c] != '0);
      if (nonempty[c]) begin
        sel     = CH_W'(c);
        any_msg = 1'b1;
      end
    end
  end

  assign post_ch       = s1_ch_r[CH_W-1:0];
  assign post_in_range = int'(s1_ch_r) < smf_pkg::CHANNELS;
  assign post_ok       = (s1_op_r == smf_pkg::OP_POST) && post_in_range &&
                         (fill_r[post_ch] != CNT_W'(smf_pkg::DEPTH));
  assign get_ok        = (s1_op_r == smf_pkg::OP_GET) && any_msg;

  always_comb begin
    case (s1_op_r)
      smf_pkg::OP_POST:  res_ok = post_ok;
      smf_pkg::OP_GET:   res_ok = get_ok;
      smf_pkg::OP_FLUSH: res_ok = 1'b1;
      default:           res_ok = 1'b0;
    endcase
  end

  always_comb begin
    over_fill = 1'b0;
    for (int c = 0; c < smf_pkg::CHANNELS; c++) begin
      head_nxt[c] = head_r[c];
      tail_nxt[c] = tail_r[c];
      fill_nxt[c] = fill_r[c];
      if (fill_r[c] > CNT_W'(smf_pkg::DEPTH)) begin
        over_fill = 1'b1;
      end
      if (s1_fire) begin
        case (s1_op_r)
          smf_pkg::OP_POST: begin
            if (post_ok && int'(post_ch) == c) begin
              tail_nxt[c] = smf_pkg::next_idx(tail_r[c]);
              fill_nxt[c] = fill_r[c] + 1'b1;
            end
          end
          smf_pkg::OP_GET: begin
            if (get_ok && int'(sel) == c) begin
              head_nxt[c] = smf_pkg::next_idx(head_r[c]);
              fill_nxt[c] = fill_r[c] - 1'b1;
            end
          end
          smf_pkg::OP_FLUSH: begin
            // a register naming a missing channel matches no lane
            if (int'(touch_ch_r) == c || int'(key_ch_r) == c) begin
              head_nxt[c] = '0;
              tail_nxt[c] = '0;
              fill_nxt[c] = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '{default: '0};
      tail_r <= '{default: '0};
      fill_r <= '{default: '0};
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // message store: one port, write on post, read on get
  smf_pkg::msg_t    mem [2**MEM_AW];
  smf_pkg::msg_t    rd_data_r;
  logic [MEM_AW-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;

  assign mem_we   = s1_fire && post_ok;
  assign mem_re   = s1_fire && get_ok;
  assign mem_addr = mem_we ? {post_ch, tail_r[post_ch]} : {sel, head_r[sel]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= s1_msg_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // result register
  logic                         ok_r;
  logic                         got_r;
  logic [smf_pkg::CH_OUT_W-1:0] ch_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      ok_r     <= res_ok;
      got_r    <= get_ok;
      ch_out_r <= get_ok ? smf_pkg::CH_OUT_W'(sel) : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = ok_r;
  assign out_chan.channel_out = ch_out_r;
  assign out_chan.code_out    = got_r ? rd_data_r.code   : '0;
  assign out_chan.word_w_out  = got_r ? rd_data_r.word_w : '0;
  assign out_chan.word_l_out  = got_r ? rd_data_r.word_l : '0;
  assign out_chan.word_z_out  = got_r ? rd_data_r.word_z : '0;

  // checks
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    !over_fill)
    else $error("fill count beyond queue depth");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && get_ok) |=> (fill_r[$past(sel)] == $past(fill_r[sel]) - 1'b1))
    else $error("get did not pop the selected channel");

  a_post_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (fill_nxt[post_ch] != '0))
    else $error("post accepted without queue growth");

endmodule
